// ===== src/pss_pkg.sv =====
// Shared types and codes for the priority source selector.
`timescale 1ns / 1ps
package pss_pkg;

    localparam int KIND_W   = 3;
    localparam int PRI_W    = 8;
    localparam int COMP_W   = 4;
    localparam int MODE_W   = 2;
    localparam int AMOUNT_W = 32;
    localparam int MASK_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REGISTER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_TMO   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MANUAL    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SET_AUTO  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd7;

    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_ENDLESS  = 2'd1;
    localparam logic [1:0] ST_TIMED    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ENDLESS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIMED   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COMP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_MASK   = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PRI_W-1:0]    priority_req;
        logic [COMP_W-1:0]   component;
        logic [MODE_W-1:0]   timeout_mode;
        logic [AMOUNT_W-1:0] time_amount;
        logic                flag;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [PRI_W-1:0]  visible_priority;
        logic [COMP_W-1:0] visible_component;
        logic              visible_changed;
        logic              component_changed;
        logic              list_changed;
        logic [COMP_W-1:0] slot_component;
    } t_out_item;

endpackage

// ===== src/pss_ifs.sv =====
// Handshake channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
interface pss_in_if;
    logic              valid;
    logic              ready;
    pss_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if;
    logic               valid;
    logic               ready;
    pss_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pss_pkg::CFG_IDX_W-1:0]   index;
    logic [pss_pkg::MASK_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/priority_source_selector_core.sv =====
// Priority source selector: slot table in memory scanned by a shared sequencer.
// Tick, clear, set timeout with activity change and manual/auto switch run a full
//   scan of the table (one memory read per slot); register and query do not.
// Non-forced clear-all runs one full scan per removed slot: up to (NUM_SLOTS-2) scans.
// Forced clear-all rewrites every entry. One item at a time.
// Reset: synchronous; after it a clearing pass writes the table
//   before the first beat is taken; config writes are taken at any time.
`timescale 1ns / 1ps
module priority_source_selector_core #(
    parameter int NUM_SLOTS = 256,
    parameter int TIME_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pss_in_if.sink    i_in,
    pss_out_if.source o_out,
    pss_cfg_if.sink   i_cfg
);
    import pss_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = ((SW > PRI_W) ? SW : PRI_W) + 1;
    localparam int AW = ((TIME_BITS > AMOUNT_W) ? TIME_BITS : AMOUNT_W) + 1;
    localparam int EW = 1 + 2 + COMP_W + TIME_BITS;
    localparam logic [SW-1:0] SLOWEST    = SW'(NUM_SLOTS - 1);
    localparam logic [SW-1:0] BACKGROUND = SW'(NUM_SLOTS - 2);
    localparam logic [SW:0]   NO_MANUAL  = (SW+1)'(NUM_SLOTS);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_FETCH, S_CA_RD, S_CA_CHK,
        S_EV_INIT, S_EVAL, S_EV_SEL, S_EV_COMP, S_OUT
    } t_state;

    t_state r_state;

    logic [EW-1:0] mem [NUM_SLOTS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [SW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    logic [COMP_W-1:0]    r_defcomp;
    logic [MASK_W-1:0]    r_mask;
    t_in_item             r_item;
    logic [SW-1:0]        r_shown, r_old_pri, r_best, r_sel, r_k, r_cidx;
    logic [COMP_W-1:0]    r_shown_comp, r_old_comp, r_qcomp;
    logic [SW:0]          r_manual, r_cnt, r_ecnt;
    logic                 r_auto, r_ok, r_listc, r_found, r_man_pres;
    logic                 r_evv, r_post_clr, r_in_ca, r_sweep_out;
    logic [SW-1:0]        r_evi;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_ovalid;
    t_out_item            r_out;

    // read data fields
    logic                 rd_present;
    logic [1:0]           rd_status;
    logic [COMP_W-1:0]    rd_comp;
    logic [TIME_BITS-1:0] rd_exp;
    assign {rd_present, rd_status, rd_comp, rd_exp} = r_rd;

    // item slot decode
    logic [CW-1:0] in_ext, it_ext;
    logic [SW-1:0] in_idx, it_idx;
    logic          it_valid;
    assign in_ext   = CW'(i_in.data.priority_req);
    assign in_idx   = in_ext[SW-1:0];
    assign it_ext   = CW'(r_item.priority_req);
    assign it_idx   = it_ext[SW-1:0];
    assign it_valid = it_ext < CW'(NUM_SLOTS);

    // shared saturating time adder
    logic [AMOUNT_W-1:0]  add_b;
    logic [AW-1:0]        add_sum;
    logic [TIME_BITS-1:0] add_sat;
    assign add_b   = (r_state == S_IDLE) ? i_in.data.time_amount : r_item.time_amount;
    assign add_sum = AW'(r_now) + AW'(add_b);
    assign add_sat = (add_sum > AW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                        : add_sum[TIME_BITS-1:0];

    // set timeout: new status and expiry
    logic [1:0]           to_ns;
    logic [TIME_BITS-1:0] to_exp;
    logic                 to_change;
    always_comb begin
        to_exp = rd_exp;
        if (r_item.timeout_mode == MODE_TIMED) begin
            to_ns  = ST_TIMED;
            to_exp = add_sat;
        end else if (rd_status == ST_TIMED) begin
            to_ns  = ST_TIMED;
            to_exp = r_now;
        end else begin
            to_ns = (r_item.timeout_mode == MODE_ENDLESS) ? ST_ENDLESS : ST_INACTIVE;
        end
        to_change = (rd_status == ST_INACTIVE) != (to_ns == ST_INACTIVE);
    end

    logic ev_drop, clr_ok, ca_hit, man_ok, auto_ok;
    logic [SW-1:0] best_final;
    assign ev_drop = rd_present && (r_evi != SLOWEST) && (rd_status == ST_TIMED)
                     && (rd_exp <= r_now);
    assign clr_ok  = it_valid && (it_idx < SLOWEST) && rd_present;
    assign ca_hit  = rd_present && r_mask[rd_comp];
    assign man_ok  = it_valid && rd_present;
    assign auto_ok = (r_auto != r_item.flag)
                     && (r_item.flag || ((r_manual < NO_MANUAL) && rd_present));
    assign best_final = (!r_auto && r_man_pres) ? r_manual[SW-1:0] : r_best;

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        unique case (r_state)
            S_SWEEP: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[SW-1:0];
                if (r_cnt[SW-1:0] == SLOWEST)
                    mem_wd = {1'b1, ST_ENDLESS, r_defcomp, {TIME_BITS{1'b0}}};
            end
            S_IDLE: begin
                mem_ra = (i_in.data.kind == KIND_SET_AUTO) ? r_manual[SW-1:0] : in_idx;
            end
            S_FETCH: begin
                mem_wa = it_idx;
                case (r_item.kind)
                    KIND_REGISTER: begin
                        mem_we = it_valid;
                        mem_wd = {1'b1, rd_present ? rd_status : ST_INACTIVE,
                                  r_item.component, rd_exp};
                    end
                    KIND_SET_TMO: begin
                        mem_we = man_ok;
                        mem_wd = {1'b1, to_ns, rd_comp, to_exp};
                    end
                    KIND_CLEAR: begin
                        mem_we = clr_ok;
                        mem_wd = {1'b0, ST_INACTIVE, rd_comp, rd_exp};
                    end
                    default: mem_we = 1'b0;
                endcase
            end
            S_CA_RD: mem_ra = r_k;
            S_CA_CHK: begin
                mem_we = ca_hit;
                mem_wa = r_k;
                mem_wd = {1'b0, ST_INACTIVE, rd_comp, rd_exp};
            end
            S_EVAL: begin
                mem_ra = r_ecnt[SW-1:0];
                mem_we = r_evv && ev_drop;
                mem_wa = r_evi;
                mem_wd = {1'b0, ST_INACTIVE, rd_comp, rd_exp};
            end
            S_EV_SEL: mem_ra = best_final;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    logic [CW-1:0] shown_ext;
    assign shown_ext = CW'(r_shown);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_cnt        <= '0;
            r_sweep_out  <= 1'b0;
            r_defcomp    <= '0;
            r_mask       <= 16'd7;
            r_shown      <= SLOWEST;
            r_shown_comp <= '0;
            r_manual     <= NO_MANUAL;
            r_auto       <= 1'b1;
            r_now        <= '0;
            r_ovalid     <= 1'b0;
            r_evv        <= 1'b0;
            r_post_clr   <= 1'b0;
            r_in_ca      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_DEFAULT_COMP: r_defcomp <= i_cfg.data[COMP_W-1:0];
                    CFG_CLEAR_MASK:   r_mask    <= i_cfg.data;
                    default:          r_mask    <= r_mask;
                endcase
            end
            // drop the beat once taken; the output state reloads it itself
            if (r_ovalid && o_out.ready && r_state != S_OUT)
                r_ovalid <= 1'b0;

            unique case (r_state)
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[SW-1:0] == SLOWEST)
                        r_state <= r_sweep_out ? S_OUT : S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item      <= i_in.data;
                        r_old_pri   <= r_shown;
                        r_old_comp  <= r_shown_comp;
                        r_listc     <= 1'b0;
                        r_ok        <= 1'b0;
                        r_qcomp     <= '0;
                        r_post_clr  <= 1'b0;
                        r_in_ca     <= 1'b0;
                        r_sweep_out <= 1'b0;
                        unique case (i_in.data.kind)
                            KIND_TICK: begin
                                r_now   <= add_sat;
                                r_ok    <= 1'b1;
                                r_state <= S_EV_INIT;
                            end
                            KIND_CLEAR_ALL: begin
                                r_ok <= 1'b1;
                                if (i_in.data.flag) begin
                                    r_shown     <= SLOWEST;
                                    r_cnt       <= '0;
                                    r_sweep_out <= 1'b1;
                                    r_state     <= S_SWEEP;
                                end else begin
                                    r_k     <= '0;
                                    r_in_ca <= 1'b1;
                                    r_state <= S_CA_RD;
                                end
                            end
                            default: r_state <= S_FETCH;
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_OUT;
                    case (r_item.kind)
                        KIND_REGISTER: begin
                            r_ok <= it_valid;
                            if (it_valid && ((!rd_present && !r_auto) || (rd_present
                                && (r_shown_comp == r_item.component
                                    || rd_comp == r_item.component))))
                                r_listc <= 1'b1;
                        end
                        KIND_SET_TMO: begin
                            if (man_ok) begin
                                r_ok <= 1'b1;
                                if (to_change) begin
                                    if (r_shown < it_idx)
                                        r_listc <= 1'b1;
                                    r_state <= S_EV_INIT;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            if (clr_ok) begin
                                r_ok       <= 1'b1;
                                r_cidx     <= it_idx;
                                r_post_clr <= 1'b1;
                                r_state    <= S_EV_INIT;
                            end
                        end
                        KIND_MANUAL: begin
                            if (man_ok) begin
                                r_ok     <= 1'b1;
                                r_manual <= {1'b0, it_idx};
                                if (r_auto) begin
                                    r_auto  <= 1'b0;
                                    r_state <= S_EV_INIT;
                                end
                            end
                        end
                        KIND_SET_AUTO: begin
                            if (auto_ok) begin
                                r_ok    <= 1'b1;
                                r_auto  <= r_item.flag;
                                r_state <= S_EV_INIT;
                            end
                        end
                        default: begin
                            r_ok    <= man_ok;
                            r_qcomp <= man_ok ? rd_comp : '0;
                        end
                    endcase
                end
                S_CA_RD: begin
                    r_post_clr <= 1'b0;
                    r_state    <= (r_k < BACKGROUND) ? S_CA_CHK : S_OUT;
                end
                S_CA_CHK: begin
                    if (ca_hit) begin
                        r_cidx     <= r_k;
                        r_post_clr <= 1'b1;
                        r_state    <= S_EV_INIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CA_RD;
                    end
                end
                S_EV_INIT: begin
                    r_best     <= SLOWEST;
                    r_found    <= 1'b0;
                    r_man_pres <= 1'b0;
                    r_ecnt     <= '0;
                    r_evv      <= 1'b0;
                    r_state    <= S_EVAL;
                end
                S_EVAL: begin
                    // issue one read per cycle, process the previous one
                    r_evv  <= (r_ecnt < (SW+1)'(NUM_SLOTS));
                    r_evi  <= r_ecnt[SW-1:0];
                    r_ecnt <= r_ecnt + 1'b1;
                    if (r_evv) begin
                        if (ev_drop) begin
                            r_listc <= 1'b1;
                        end else if (rd_present && rd_status != ST_INACTIVE && !r_found) begin
                            r_best  <= r_evi;
                            r_found <= 1'b1;
                        end
                        // slot zero wins whenever present at scan start
                        if (r_evi == '0 && rd_present) begin
                            r_best  <= '0;
                            r_found <= 1'b1;
                        end
                        if (r_manual == {1'b0, r_evi})
                            r_man_pres <= rd_present && !ev_drop;
                        if (r_evi == SLOWEST) begin
                            r_evv   <= 1'b0;
                            r_state <= S_EV_SEL;
                        end
                    end
                end
                S_EV_SEL: begin
                    if (!r_auto && !r_man_pres)
                        r_auto <= 1'b1;
                    r_sel   <= best_final;
                    r_state <= S_EV_COMP;
                end
                S_EV_COMP: begin
                    r_shown      <= r_sel;
                    r_shown_comp <= rd_comp;
                    if (r_sel != r_shown || rd_comp != r_shown_comp)
                        r_listc <= 1'b1;
                    if (r_post_clr && ((!r_auto && r_sel < r_cidx) || r_sel == BACKGROUND))
                        r_listc <= 1'b1;
                    if (r_in_ca) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CA_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid                <= 1'b1;
                        r_out.ok                <= r_ok;
                        r_out.visible_priority  <= shown_ext[PRI_W-1:0];
                        r_out.visible_component <= r_shown_comp;
                        r_out.visible_changed   <= (r_shown != r_old_pri)
                                                   || (r_shown_comp != r_old_comp);
                        r_out.component_changed <= (r_shown_comp != r_old_comp);
                        r_out.list_changed      <= r_listc;
                        r_out.slot_component    <= r_qcomp;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_manual_when_auto_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_auto |-> (r_manual < NO_MANUAL))
        else $error("auto selection off without a manual slot");
    a_shown_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_shown) < CW'(NUM_SLOTS)))
        else $error("shown priority out of range");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready while an item is in work");
    a_scan_exits_at_slowest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_evv && r_evi == SLOWEST) |=> (r_state == S_EV_SEL))
        else $error("scan did not end at slowest slot");
`endif

endmodule
